// ----- src/lc3x_pkg.sv -----
package lc3x_pkg;

	localparam logic [3:0] OP_BR   = 4'h0;
	localparam logic [3:0] OP_ADD  = 4'h1;
	localparam logic [3:0] OP_LD   = 4'h2;
	localparam logic [3:0] OP_ST   = 4'h3;
	localparam logic [3:0] OP_JSR  = 4'h4;
	localparam logic [3:0] OP_AND  = 4'h5;
	localparam logic [3:0] OP_LDR  = 4'h6;
	localparam logic [3:0] OP_STR  = 4'h7;
	localparam logic [3:0] OP_RTI  = 4'h8;
	localparam logic [3:0] OP_NOT  = 4'h9;
	localparam logic [3:0] OP_LDI  = 4'hA;
	localparam logic [3:0] OP_STI  = 4'hB;
	localparam logic [3:0] OP_JMP  = 4'hC;
	localparam logic [3:0] OP_RES  = 4'hD;
	localparam logic [3:0] OP_LEA  = 4'hE;
	localparam logic [3:0] OP_TRAP = 4'hF;

	localparam logic [7:0] TV_GETC  = 8'h20;
	localparam logic [7:0] TV_OUT   = 8'h21;
	localparam logic [7:0] TV_PUTS  = 8'h22;
	localparam logic [7:0] TV_IN    = 8'h23;
	localparam logic [7:0] TV_PUTSP = 8'h24;
	localparam logic [7:0] TV_HALT  = 8'h25;

	localparam logic [2:0] EV_NONE  = 3'd0;
	localparam logic [2:0] EV_GETC  = 3'd1;
	localparam logic [2:0] EV_OUT   = 3'd2;
	localparam logic [2:0] EV_PUTS  = 3'd3;
	localparam logic [2:0] EV_IN    = 3'd4;
	localparam logic [2:0] EV_PUTSP = 3'd5;
	localparam logic [2:0] EV_HALT  = 3'd6;
	localparam logic [2:0] EV_BAD   = 3'd7;

	localparam logic [1:0] KIND_EXEC  = 2'd0;
	localparam logic [1:0] KIND_WRITE = 2'd1;
	localparam logic [1:0] KIND_KDOWN = 2'd2;
	localparam logic [1:0] KIND_KUP   = 2'd3;

	localparam logic [15:0] KBSR_ADDR      = 16'hFE00;
	localparam logic [15:0] KBDR_ADDR      = 16'hFE02;
	localparam logic [15:0] KBSR_READY     = 16'h8000;
	localparam logic [15:0] START_PC_RESET = 16'h3000;
	localparam logic [2:0]  CC_RESET       = 3'b010;

	typedef struct packed {
		logic [7:0]  key_code;
		logic [15:0] data;
		logic [15:0] address;
		logic [1:0]  kind;
	} item_t;

	typedef struct packed {
		logic        halted;
		logic [15:0] string_address;
		logic [7:0]  out_char;
		logic [2:0]  trap_event;
		logic [2:0]  flags_nzp;
		logic [15:0] next_pc;
	} result_t;

	function automatic logic [2:0] nzp(input logic [15:0] v);
		if (v[15]) begin
			return 3'b100;
		end else if (v == 16'h0000) begin
			return 3'b010;
		end
		return 3'b001;
	endfunction

endpackage

// ----- src/lc3x_ram.sv -----
module lc3x_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- src/lc3x_exec.sv -----
module lc3x_exec #(
	parameter int MEM_WORDS = 65536
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  lc3x_pkg::item_t   item,
	output logic              item_take,
	output logic              clearing,
	output logic              res_valid,
	input  logic              res_ready,
	output lc3x_pkg::result_t res,
	input  logic              cfg_we,
	input  logic [15:0]       cfg_wdata
);

	localparam int AW = $clog2(MEM_WORDS);

	typedef enum logic [3:0] {
		ST_CLR, ST_IDLE, ST_FETCH, ST_EXEC, ST_RD, ST_KBS, ST_KBD, ST_LDV, ST_WR0, ST_DONE
	} state_t;

	state_t        state_q;
	logic [AW-1:0] clr_cnt_q;
	logic [15:0]   pc_q;
	logic [2:0]    cc_q;
	logic          pending_q;
	logic [7:0]    last_key_q;
	logic          halt_q;
	logic [15:0]   ins_q;
	logic [15:0]   rb_q;
	logic          phase_q;
	logic [15:0]   kbval_q;
	logic          kbwr_q;
	logic [2:0]    ev_q;
	logic [7:0]    ch_q;
	logic [15:0]   sa_q;

	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [15:0]   mem_wdata;
	logic [AW-1:0] mem_raddr;
	logic [15:0]   mem_rdata;
	logic          rf_we;
	logic [2:0]    rf_waddr;
	logic [15:0]   rf_wdata;
	logic [2:0]    rfa_addr;
	logic [2:0]    rfb_addr;
	logic [15:0]   ra;
	logic [15:0]   rb;
	logic          cc_we;

	logic [3:0]    op;
	logic [2:0]    dr;
	logic [15:0]   off9;
	logic [15:0]   off6;
	logic [15:0]   off11;
	logic [15:0]   imm5;
	logic [15:0]   ea;
	logic [15:0]   alu;
	logic [15:0]   ld_val;
	logic          ld_req;
	logic [15:0]   ld_addr;
	logic          kb_hit;
	logic          finishing;
	logic [3:0]    f_op;

	assign op    = ins_q[15:12];
	assign dr    = ins_q[11:9];
	assign off9  = {{7{ins_q[8]}}, ins_q[8:0]};
	assign off6  = {{10{ins_q[5]}}, ins_q[5:0]};
	assign off11 = {{5{ins_q[10]}}, ins_q[10:0]};
	assign imm5  = {{11{ins_q[4]}}, ins_q[4:0]};
	assign f_op  = mem_rdata[15:12];

	assign ea        = (op == lc3x_pkg::OP_LDR || op == lc3x_pkg::OP_STR) ? ra + off6 : pc_q + off9;
	assign finishing = (state_q == ST_RD) || (state_q == ST_LDV);
	assign ld_val    = (state_q == ST_LDV) ? kbval_q : mem_rdata;

	always_comb begin
		case (op)
			lc3x_pkg::OP_ADD: alu = ra + (ins_q[5] ? imm5 : rb);
			lc3x_pkg::OP_AND: alu = ra & (ins_q[5] ? imm5 : rb);
			lc3x_pkg::OP_NOT: alu = ~ra;
			default:          alu = pc_q + off9;
		endcase
	end

	// Load sequencing: first read from execute, pointer follow-up for LDI.
	always_comb begin
		ld_req  = 1'b0;
		ld_addr = ea;
		if (state_q == ST_EXEC) begin
			ld_req = (op == lc3x_pkg::OP_LD) || (op == lc3x_pkg::OP_LDR) ||
				(op == lc3x_pkg::OP_LDI) || (op == lc3x_pkg::OP_STI);
		end else if (finishing && op == lc3x_pkg::OP_LDI && !phase_q) begin
			ld_req  = 1'b1;
			ld_addr = ld_val;
		end
	end
	assign kb_hit = ld_req && (ld_addr == lc3x_pkg::KBSR_ADDR);

	always_comb begin
		mem_raddr = (state_q == ST_IDLE) ? pc_q[AW-1:0] : ld_addr[AW-1:0];
		mem_we    = 1'b0;
		mem_waddr = ea[AW-1:0];
		mem_wdata = rb;
		case (state_q)
			ST_CLR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_cnt_q;
				mem_wdata = '0;
			end
			ST_IDLE: begin
				mem_we    = item_valid && item.kind == lc3x_pkg::KIND_WRITE;
				mem_waddr = item.address[AW-1:0];
				mem_wdata = item.data;
			end
			ST_EXEC: begin
				mem_we = (op == lc3x_pkg::OP_ST) || (op == lc3x_pkg::OP_STR);
			end
			ST_KBS: begin
				mem_we    = 1'b1;
				mem_waddr = lc3x_pkg::KBSR_ADDR[AW-1:0];
				mem_wdata = kbval_q;
			end
			ST_KBD: begin
				mem_we    = 1'b1;
				mem_waddr = lc3x_pkg::KBDR_ADDR[AW-1:0];
				mem_wdata = {8'h00, last_key_q};
			end
			ST_RD, ST_LDV: begin
				mem_we    = op == lc3x_pkg::OP_STI;
				mem_waddr = ld_val[AW-1:0];
				mem_wdata = rb_q;
			end
			default: ;
		endcase
	end

	always_comb begin
		rfa_addr = mem_rdata[8:6];
		case (f_op)
			lc3x_pkg::OP_ST, lc3x_pkg::OP_STR, lc3x_pkg::OP_STI: rfb_addr = mem_rdata[11:9];
			lc3x_pkg::OP_TRAP: rfb_addr = 3'd0;
			default:           rfb_addr = mem_rdata[2:0];
		endcase
	end

	always_comb begin
		rf_we    = 1'b0;
		rf_waddr = dr;
		rf_wdata = alu;
		cc_we    = 1'b0;
		case (state_q)
			ST_CLR: begin
				rf_we    = 1'b1;
				rf_waddr = clr_cnt_q[2:0];
				rf_wdata = '0;
			end
			ST_EXEC: begin
				case (op)
					lc3x_pkg::OP_ADD, lc3x_pkg::OP_AND, lc3x_pkg::OP_NOT, lc3x_pkg::OP_LEA: begin
						rf_we = 1'b1;
						cc_we = 1'b1;
					end
					lc3x_pkg::OP_JSR, lc3x_pkg::OP_TRAP: begin
						rf_we    = 1'b1;
						rf_waddr = 3'd7;
						rf_wdata = pc_q;
					end
					default: ;
				endcase
			end
			ST_RD, ST_LDV: begin
				rf_we    = (op == lc3x_pkg::OP_LD) || (op == lc3x_pkg::OP_LDR) ||
					(op == lc3x_pkg::OP_LDI && phase_q);
				cc_we    = rf_we;
				rf_wdata = ld_val;
			end
			ST_WR0: begin
				rf_we    = 1'b1;
				rf_waddr = 3'd0;
				rf_wdata = {8'h00, last_key_q};
			end
			default: ;
		endcase
	end

	lc3x_ram #(.WIDTH(16), .DEPTH(MEM_WORDS)) u_mem (
		.clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
		.raddr(mem_raddr), .rdata(mem_rdata)
	);

	// Two copies of the register file give two read ports.
	lc3x_ram #(.WIDTH(16), .DEPTH(8)) u_rf_a (
		.clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
		.raddr(rfa_addr), .rdata(ra)
	);
	lc3x_ram #(.WIDTH(16), .DEPTH(8)) u_rf_b (
		.clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
		.raddr(rfb_addr), .rdata(rb)
	);

	assign item_take = (state_q == ST_IDLE) && item_valid;
	assign clearing  = state_q == ST_CLR;
	assign res_valid = state_q == ST_DONE;
	assign res       = '{halted: halt_q, string_address: sa_q, out_char: ch_q,
		trap_event: ev_q, flags_nzp: cc_q, next_pc: pc_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLR;
			clr_cnt_q  <= '0;
			pc_q       <= lc3x_pkg::START_PC_RESET;
			cc_q       <= lc3x_pkg::CC_RESET;
			pending_q  <= 1'b0;
			last_key_q <= '0;
			halt_q     <= 1'b0;
			phase_q    <= 1'b0;
			kbwr_q     <= 1'b0;
			ev_q       <= lc3x_pkg::EV_NONE;
			ch_q       <= '0;
			sa_q       <= '0;
		end else begin
			if (cc_we) begin
				cc_q <= lc3x_pkg::nzp(rf_wdata);
			end
			if (kb_hit) begin
				kbval_q   <= pending_q ? lc3x_pkg::KBSR_READY : 16'h0000;
				kbwr_q    <= pending_q;
				pending_q <= 1'b0;
			end
			case (state_q)
				ST_CLR: begin
					clr_cnt_q <= clr_cnt_q + AW'(1);
					if (clr_cnt_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (item_valid) begin
						ev_q    <= lc3x_pkg::EV_NONE;
						ch_q    <= '0;
						sa_q    <= '0;
						phase_q <= 1'b0;
						state_q <= ST_DONE;
						case (item.kind)
							lc3x_pkg::KIND_EXEC: begin
								if (!halt_q) begin
									state_q <= ST_FETCH;
								end
							end
							lc3x_pkg::KIND_KDOWN: begin
								pending_q  <= 1'b1;
								last_key_q <= item.key_code;
							end
							lc3x_pkg::KIND_KUP: pending_q <= 1'b0;
							default: ;
						endcase
					end
				end
				ST_FETCH: begin
					ins_q   <= mem_rdata;
					pc_q    <= pc_q + 16'd1;
					state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					rb_q    <= rb;
					state_q <= ST_DONE;
					if (ld_req) begin
						state_q <= kb_hit ? ST_KBS : ST_RD;
					end
					case (op)
						lc3x_pkg::OP_BR: begin
							if ((cc_q & dr) != 3'b000) begin
								pc_q <= pc_q + off9;
							end
						end
						lc3x_pkg::OP_JSR: pc_q <= ins_q[11] ? pc_q + off11 : ra;
						lc3x_pkg::OP_JMP: pc_q <= ra;
						lc3x_pkg::OP_TRAP: begin
							case (ins_q[7:0])
								lc3x_pkg::TV_GETC: begin
									ev_q    <= lc3x_pkg::EV_GETC;
									state_q <= ST_WR0;
								end
								lc3x_pkg::TV_OUT: begin
									ev_q <= lc3x_pkg::EV_OUT;
									ch_q <= rb[7:0];
								end
								lc3x_pkg::TV_PUTS: begin
									ev_q <= lc3x_pkg::EV_PUTS;
									sa_q <= rb;
								end
								lc3x_pkg::TV_IN: ev_q <= lc3x_pkg::EV_IN;
								lc3x_pkg::TV_PUTSP: begin
									ev_q <= lc3x_pkg::EV_PUTSP;
									sa_q <= rb;
								end
								lc3x_pkg::TV_HALT: begin
									ev_q   <= lc3x_pkg::EV_HALT;
									halt_q <= 1'b1;
								end
								default: ev_q <= lc3x_pkg::EV_BAD;
							endcase
						end
						lc3x_pkg::OP_ADD, lc3x_pkg::OP_LD, lc3x_pkg::OP_ST,
						lc3x_pkg::OP_AND, lc3x_pkg::OP_LDR, lc3x_pkg::OP_STR, lc3x_pkg::OP_NOT,
						lc3x_pkg::OP_LDI, lc3x_pkg::OP_STI, lc3x_pkg::OP_LEA: ;
						default: ev_q <= lc3x_pkg::EV_BAD;
					endcase
				end
				ST_RD, ST_LDV: begin
					if (ld_req) begin
						phase_q <= 1'b1;
						state_q <= kb_hit ? ST_KBS : ST_RD;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_KBS:  state_q <= kbwr_q ? ST_KBD : ST_LDV;
				ST_KBD:  state_q <= ST_LDV;
				ST_WR0:  state_q <= ST_DONE;
				ST_DONE: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (cfg_we) begin
				pc_q <= cfg_wdata;
			end
		end
	end

	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halt_q |=> halt_q) else $error("halt latch dropped");
	a_kbd_after_kbs: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_KBD |-> $past(state_q == ST_KBS)) else $error("bad keyboard sequence");
	a_kb_pending_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_KBS || state_q == ST_KBD) |-> !pending_q)
		else $error("key pending not cleared on status read");
	a_done_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !mem_we && !rf_we) else $error("write while result waits");

endmodule

// ----- src/lc3_instruction_execute.sv -----
// Channel   Dir  Word                                              Handshake
// s_axis    in   tuser: kind; tdata: address, data, key_code       tvalid/tready
// m_axis    out  tdata: next_pc, flags_nzp, trap_event, out_char,  tvalid/tready
//                string_address, halted
// cfg       in   cfg_wdata loads the program counter               cfg_we, no wait
//
// Write, key and halted-execute words go from idle to done; an execute word passes fetch
// and execute too, with the most states for LDI through the keyboard status word. All
// memory traffic goes through the single write port and single read port of the main
// memory, one access per step. After reset a clearing pass writes zero to all MEM_WORDS
// entries, one per cycle, with s_axis_tready low. Config writes are taken at any time.
// A one-word input buffer takes the next word while one executes; the output register
// holds a result while m_axis_tready is low. MEM_WORDS must be a power of two.
module lc3_instruction_execute #(
	parameter int MEM_WORDS = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // address[15:0], data[31:16], key_code[39:32]
	input  logic [1:0]  s_axis_tuser,  // kind
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// next_pc[15:0], flags_nzp[18:16], trap_event[21:19], out_char[29:22],
	// string_address[45:30], halted[46], zero[47]
	output logic [47:0] m_axis_tdata,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);

	logic              ib_full_q;
	lc3x_pkg::item_t   ib_q;
	logic              item_take;
	logic              clearing;
	logic              res_valid;
	logic              res_ready;
	lc3x_pkg::result_t res;
	logic              out_valid_q;
	lc3x_pkg::result_t out_q;

	assign s_axis_tready = !ib_full_q && !clearing;
	assign res_ready     = !out_valid_q || m_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, out_q};

	// input buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ib_full_q <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				ib_full_q <= 1'b1;
				ib_q      <= {s_axis_tdata, s_axis_tuser};
			end else if (item_take) begin
				ib_full_q <= 1'b0;
			end
		end
	end

	lc3x_exec #(.MEM_WORDS(MEM_WORDS)) u_exec (
		.clk(clk), .arst_n(arst_n),
		.item_valid(ib_full_q), .item(ib_q), .item_take(item_take),
		.clearing(clearing),
		.res_valid(res_valid), .res_ready(res_ready), .res(res),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (res_valid && res_ready) begin
				out_valid_q <= 1'b1;
				out_q       <= res;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- sim/tb_top.sv -----
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 200000;	// covers the memory clear after reset

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata = '0;	// address[15:0], data[31:16], key_code[39:32]
	logic [1:0]  s_axis_tuser = '0;	// kind
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;	// next_pc, flags_nzp, trap_event, out_char, string_address, halted
	logic        cfg_we = 1'b0;
	logic [15:0] cfg_wdata = '0;

	lc3_instruction_execute dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// Core model: architectural state mirrored in the bench
	// ---------------------------------------------------------------
	logic [15:0] core_mem [0:65535];
	logic [15:0] core_reg [0:7];
	logic [15:0] core_pc;
	logic [2:0]  core_cc;
	logic        core_key_pending;
	logic [7:0]  core_last_key;
	logic        core_halted;

	lc3x_pkg::item_t   word_q [$];	// words waiting to be offered
	lc3x_pkg::result_t result_q [$];	// expected results, oldest first
	int                errors = 0;

	function automatic logic [2:0] cc_of(input logic [15:0] v);
		if (v[15]) return 3'b100;
		if (v == 16'h0000) return 3'b010;
		return 3'b001;
	endfunction

	// memory read with the keyboard status side effect
	function automatic logic [15:0] core_read(input logic [15:0] a);
		if (a == lc3x_pkg::KBSR_ADDR) begin
			if (core_key_pending) begin
				core_mem[lc3x_pkg::KBSR_ADDR] = lc3x_pkg::KBSR_READY;
				core_mem[lc3x_pkg::KBDR_ADDR] = {8'h00, core_last_key};
				core_key_pending = 1'b0;
			end else begin
				core_mem[lc3x_pkg::KBSR_ADDR] = 16'h0000;
			end
		end
		return core_mem[a];
	endfunction

	function automatic lc3x_pkg::result_t core_step(input lc3x_pkg::item_t it);
		lc3x_pkg::result_t r;
		logic [15:0] ins, v, off9, off6;
		logic [3:0] op;
		logic [2:0] dr, sr;
		r = '0;
		case (it.kind)
			lc3x_pkg::KIND_WRITE: core_mem[it.address] = it.data;
			lc3x_pkg::KIND_KDOWN: begin
				core_key_pending = 1'b1;
				core_last_key = it.key_code;
			end
			lc3x_pkg::KIND_KUP: core_key_pending = 1'b0;
			default: if (!core_halted) begin
				ins = core_mem[core_pc];
				op = ins[15:12];
				dr = ins[11:9];
				sr = ins[8:6];
				off9 = {{7{ins[8]}}, ins[8:0]};
				off6 = {{10{ins[5]}}, ins[5:0]};
				core_pc = core_pc + 16'd1;
				r.trap_event = lc3x_pkg::EV_NONE;
				case (op)
					lc3x_pkg::OP_BR: if (|(core_cc & dr)) core_pc = core_pc + off9;
					lc3x_pkg::OP_ADD, lc3x_pkg::OP_AND: begin
						v = ins[5] ? {{11{ins[4]}}, ins[4:0]} : core_reg[ins[2:0]];
						v = (op == lc3x_pkg::OP_ADD) ? core_reg[sr] + v : core_reg[sr] & v;
						core_reg[dr] = v;
						core_cc = cc_of(v);
					end
					lc3x_pkg::OP_LD, lc3x_pkg::OP_LDR, lc3x_pkg::OP_LDI, lc3x_pkg::OP_LEA: begin
						if (op == lc3x_pkg::OP_LD) v = core_read(core_pc + off9);
						else if (op == lc3x_pkg::OP_LDR) v = core_read(core_reg[sr] + off6);
						else if (op == lc3x_pkg::OP_LDI) v = core_read(core_read(core_pc + off9));
						else v = core_pc + off9;
						core_reg[dr] = v;
						core_cc = cc_of(v);
					end
					lc3x_pkg::OP_ST: core_mem[core_pc + off9] = core_reg[dr];
					lc3x_pkg::OP_STR: core_mem[core_reg[sr] + off6] = core_reg[dr];
					lc3x_pkg::OP_STI: begin
						v = core_read(core_pc + off9);
						core_mem[v] = core_reg[dr];
					end
					lc3x_pkg::OP_JSR: begin
						v = core_pc;
						if (ins[11]) core_pc = core_pc + {{5{ins[10]}}, ins[10:0]};
						else core_pc = core_reg[sr];
						core_reg[7] = v;
					end
					lc3x_pkg::OP_NOT: begin
						v = ~core_reg[sr];
						core_reg[dr] = v;
						core_cc = cc_of(v);
					end
					lc3x_pkg::OP_JMP: core_pc = core_reg[sr];
					lc3x_pkg::OP_TRAP: begin
						core_reg[7] = core_pc;
						case (ins[7:0])
							lc3x_pkg::TV_GETC: begin
								core_reg[0] = {8'h00, core_last_key};
								r.trap_event = lc3x_pkg::EV_GETC;
							end
							lc3x_pkg::TV_OUT: begin
								r.out_char = core_reg[0][7:0];
								r.trap_event = lc3x_pkg::EV_OUT;
							end
							lc3x_pkg::TV_PUTS: begin
								r.string_address = core_reg[0];
								r.trap_event = lc3x_pkg::EV_PUTS;
							end
							lc3x_pkg::TV_IN: r.trap_event = lc3x_pkg::EV_IN;
							lc3x_pkg::TV_PUTSP: begin
								r.string_address = core_reg[0];
								r.trap_event = lc3x_pkg::EV_PUTSP;
							end
							lc3x_pkg::TV_HALT: begin
								core_halted = 1'b1;
								r.trap_event = lc3x_pkg::EV_HALT;
							end
							default: r.trap_event = lc3x_pkg::EV_BAD;
						endcase
					end
					default: r.trap_event = lc3x_pkg::EV_BAD;	// RTI and reserved opcode
				endcase
			end
		endcase
		r.next_pc = core_pc;
		r.flags_nzp = core_cc;
		r.halted = core_halted;
		return r;
	endfunction

	// ---------------------------------------------------------------
	// Driver: bursts with random gaps, holds a word until taken
	// ---------------------------------------------------------------
	lc3x_pkg::item_t held_word;
	int    burst_left = 8;
	int    gap_left = 0;
	int    idle_cycles = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				result_q.push_back(core_step(held_word));
			end
			if (!(s_axis_tvalid && !s_axis_tready)) begin
				if (gap_left > 0) begin
					gap_left--;
					s_axis_tvalid <= 1'b0;
				end else if (word_q.size() > 0) begin
					held_word = word_q.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {held_word.key_code, held_word.data, held_word.address};
					s_axis_tuser <= held_word.kind;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
					end
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Receiver: stall pattern re-picked at random among three modes; one long hold-off on request
	// ---------------------------------------------------------------
	logic hold_req = 1'b0;
	int   hold_cnt = 0;
	int   rx_mode = 0;
	int   rx_tick = 0;

	always @(posedge clk) begin
		if (hold_req && hold_cnt == 0) begin
			hold_cnt = 500;
			hold_req <= 1'b0;
		end
		rx_tick++;
		if (rx_tick % 64 == 0) rx_mode = $urandom_range(0, 2);
		if (hold_cnt > 0) begin
			hold_cnt--;
			m_axis_tready <= 1'b0;
		end else begin
			case (rx_mode)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= 1'($urandom_range(0, 1));
				default: m_axis_tready <= ($urandom_range(0, 4) == 0);
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Monitor: compare each result word against the oldest expectation
	// ---------------------------------------------------------------
	task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		lc3x_pkg::result_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = lc3x_pkg::result_t'(m_axis_tdata[46:0]);
			if (result_q.size() == 0) begin
				$display("%0t: unexpected result word, expected none, actual %h", $time,
					m_axis_tdata);
				errors++;
			end else begin
				want = result_q.pop_front();
				check_field("next_pc", want.next_pc, got.next_pc);
				check_field("flags_nzp", 16'(want.flags_nzp), 16'(got.flags_nzp));
				check_field("trap_event", 16'(want.trap_event), 16'(got.trap_event));
				check_field("out_char", 16'(want.out_char), 16'(got.out_char));
				check_field("string_address", want.string_address, got.string_address);
				check_field("halted", 16'(want.halted), 16'(got.halted));
			end
		end
	end

	// watchdog: cycles with no handshake on either side
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------
	task automatic push_word(input logic [1:0] kind, input logic [15:0] a, input logic [15:0] d,
			input logic [7:0] k);
		lc3x_pkg::item_t it;
		it.kind = kind;
		it.address = a;
		it.data = d;
		it.key_code = k;
		word_q.push_back(it);
	endtask

	task automatic push_exec();
		push_word(lc3x_pkg::KIND_EXEC, 16'($urandom), 16'($urandom), 8'($urandom));
	endtask

	task automatic push_mem(input logic [15:0] a, input logic [15:0] d);
		push_word(lc3x_pkg::KIND_WRITE, a, d, 8'($urandom));
	endtask

	// sender pause: everything offered, taken and answered
	task automatic wait_drained();
		while (word_q.size() > 0 || s_axis_tvalid || result_q.size() > 0) @(posedge clk);
	endtask

	task automatic write_start_pc(input logic [15:0] v);
		wait_drained();
		repeat (20) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		core_pc = v;
	endtask

	// random instruction, memory operands biased into the data block at base+8..base+11
	function automatic logic [15:0] pick_ins(input logic [15:0] here, input logic [15:0] base);
		logic [15:0] ins, off;
		logic [7:0] vec;
		ins = 16'($urandom);
		off = base + 16'd8 + 16'($urandom_range(0, 3)) - (here + 16'd1);
		case (ins[15:12])
			lc3x_pkg::OP_LD, lc3x_pkg::OP_ST, lc3x_pkg::OP_LDI, lc3x_pkg::OP_STI:
				if ($urandom_range(0, 9) < 7) ins[8:0] = off[8:0];
			lc3x_pkg::OP_LDR, lc3x_pkg::OP_STR:
				if ($urandom_range(0, 2) == 0) ins[5:0] = 6'd0;
			lc3x_pkg::OP_TRAP: begin
				vec = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(32, 36));
				if (vec == lc3x_pkg::TV_HALT) vec = lc3x_pkg::TV_IN;	// halt is saved for the end
				ins[7:0] = vec;
			end
			default: ;
		endcase
		return ins;
	endfunction

	function automatic logic [15:0] pick_data();
		case ($urandom_range(0, 4))
			0, 1: return lc3x_pkg::KBSR_ADDR;
			2: return lc3x_pkg::KBDR_ADDR;
			3: return 16'($urandom_range(0, 15));
			default: return 16'($urandom);
		endcase
	endfunction

	// one short program: code at the current pc, data words after it, then run it
	task automatic run_fragment();
		logic [15:0] base;
		wait_drained();
		base = core_pc;
		for (int i = 0; i < 8; i++) push_mem(base + 16'(i), pick_ins(base + 16'(i), base));
		for (int i = 8; i < 12; i++) push_mem(base + 16'(i), pick_data());
		if ($urandom_range(0, 3) == 0) push_mem(16'($urandom), 16'($urandom));
		for (int i = 0; i < 8; i++) begin
			if ($urandom_range(0, 5) == 0) begin
				push_word(lc3x_pkg::KIND_KDOWN, 16'($urandom), 16'($urandom), 8'($urandom));
			end
			if ($urandom_range(0, 11) == 0) begin
				push_word(lc3x_pkg::KIND_KUP, 16'($urandom), 16'($urandom), 8'($urandom));
			end
			push_exec();
		end
	endtask

	initial begin
		logic [15:0] pc0;
		for (int i = 0; i < 65536; i++) core_mem[i] = 16'h0000;
		for (int i = 0; i < 8; i++) core_reg[i] = 16'h0000;
		core_pc = lc3x_pkg::START_PC_RESET;
		core_cc = lc3x_pkg::CC_RESET;
		core_key_pending = 1'b0;
		core_last_key = 8'h00;
		core_halted = 1'b0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed: keyboard status read with and without a key, every trap service but halt
		pc0 = lc3x_pkg::START_PC_RESET;
		push_mem(pc0, {lc3x_pkg::OP_LD, 3'd1, 9'h00F});			// R1 <- 0xFE00
		push_mem(pc0 + 16'h10, lc3x_pkg::KBSR_ADDR);
		push_mem(pc0 + 16'h1, {lc3x_pkg::OP_LDR, 3'd2, 3'd1, 6'd0});	// status read, key pending
		push_mem(pc0 + 16'h2, {lc3x_pkg::OP_LDR, 3'd3, 3'd1, 6'd0});	// status read, none pending
		push_mem(pc0 + 16'h3, {lc3x_pkg::OP_TRAP, 4'h0, lc3x_pkg::TV_GETC});
		push_mem(pc0 + 16'h4, {lc3x_pkg::OP_TRAP, 4'h0, lc3x_pkg::TV_OUT});
		push_mem(pc0 + 16'h5, {lc3x_pkg::OP_TRAP, 4'h0, lc3x_pkg::TV_PUTS});
		push_mem(pc0 + 16'h6, {lc3x_pkg::OP_TRAP, 4'h0, lc3x_pkg::TV_IN});
		push_mem(pc0 + 16'h7, {lc3x_pkg::OP_TRAP, 4'h0, lc3x_pkg::TV_PUTSP});
		push_mem(pc0 + 16'h8, {lc3x_pkg::OP_TRAP, 4'h0, 8'h00});	// unknown vector
		push_mem(pc0 + 16'h9, {lc3x_pkg::OP_RES, 12'hFFF});		// reserved opcode
		push_mem(pc0 + 16'hA, {lc3x_pkg::OP_RTI, 12'h000});		// RTI
		push_word(lc3x_pkg::KIND_KDOWN, 16'h0000, 16'h0000, 8'hFF);
		push_exec();
		push_exec();
		push_exec();
		for (int i = 0; i < 8; i++) push_exec();
		push_word(lc3x_pkg::KIND_KUP, 16'hFFFF, 16'hFFFF, 8'h00);

		// random phases, start pc across its range
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: write_start_pc(16'h0000);
				1: write_start_pc(16'hFFFF);
				2: write_start_pc(16'($urandom));
				default: write_start_pc(lc3x_pkg::START_PC_RESET);
			endcase
			for (int f = 0; f < 20; f++) begin
				if (ph == 1 && f == 3) hold_req <= 1'b1;
				run_fragment();
			end
		end

		// halt, then items after it
		wait_drained();
		push_mem(core_pc, {lc3x_pkg::OP_TRAP, 4'h0, lc3x_pkg::TV_HALT});
		push_exec();
		push_exec();
		push_word(lc3x_pkg::KIND_KDOWN, 16'($urandom), 16'($urandom), 8'($urandom));
		push_mem(16'($urandom), 16'($urandom));
		push_exec();

		wait_drained();
		repeat (30) @(posedge clk);
		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
